### sv/minmax_waveform_decimator_unit_macros.svh
// ----------------------------------------------------------------------------
// Min/max waveform decimator assertion macros
// Concurrent checks used by the decimator modules; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MINMAX_WAVEFORM_DECIMATOR_UNIT_MACROS_SVH
`define MINMAX_WAVEFORM_DECIMATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MWD_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mwd: same-cycle check failed");
// next-cycle implication
`define MWD_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mwd: next-cycle check failed");
`else
`define MWD_ASSERT_IMP(name, clk, rst, ante, cons)
`define MWD_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

### sv/mwd_pkg.sv
// ----------------------------------------------------------------------------
// Min/max waveform decimator package
// Shared widths, point and queue entry types, configuration layout.
// ----------------------------------------------------------------------------
package mwd_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COL_W      = 16;
   localparam int ROW_W      = 16;
   localparam int MAX_PTS    = 4;
   localparam int NPTS_W     = 3;
   localparam int QDEPTH     = 8;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_SCALE,
      CSR_Y_GAIN,
      CSR_CENTER_ROW,
      CSR_VIEW_FIRST_PIXEL,
      CSR_VIEW_FIRST_SAMPLE
   } csr_idx_type;

   typedef struct packed {
      logic [31:0] x_scale;
      logic [23:0] y_gain;
      logic [14:0] center_row;
      logic [47:0] view_first_pixel;
      logic [39:0] view_first_sample;
   } cfg_type;

   typedef struct packed {
      logic signed [COL_W-1:0] x;
      logic signed [ROW_W-1:0] y;
   } point_type;

   typedef struct packed {
      point_type [MAX_PTS-1:0] pts;
      logic [NPTS_W-1:0]       n;
   } evt_type;

endpackage

### sv/mwd_if.sv
// ----------------------------------------------------------------------------
// Min/max waveform decimator channels
// Valid/ready sample channel and point channel.
// ----------------------------------------------------------------------------
interface mwd_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [mwd_pkg::SAMPLE_W-1:0] sample_value;
   logic                                start_of_view;
   logic                                end_of_view;

   modport source (output valid, sample_value, start_of_view, end_of_view, input ready);
   modport sink (input valid, sample_value, start_of_view, end_of_view, output ready);
endinterface

interface mwd_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [mwd_pkg::COL_W-1:0] x_pos;
   logic signed [mwd_pkg::ROW_W-1:0] y_pos;
   logic                             last_of_run;

   modport source (output valid, x_pos, y_pos, last_of_run, input ready);
   modport sink (input valid, x_pos, y_pos, last_of_run, output ready);
endinterface

### sv/minmax_waveform_decimator_unit.sv
// ----------------------------------------------------------------------------
// Min/max waveform decimator
// Turns a sample stream into polyline corner points, at most four points per
// pixel column: entry, max, min and exit rows of each column.
//
//   channel  dir  handshake          payload
//   req      in   valid/ready        sample_value, start_of_view, end_of_view
//   rsp      out  valid/ready        x_pos, y_pos, last_of_run
//   csr      in   csr_wr_en          csr_index, csr_wdata
//
// One sample is accepted per cycle while the point queue has room for all
// samples in flight; its points pass through the a and b pipeline registers,
// the point queue and the registered output stage, which sends one point per
// cycle while rsp.ready is high. Sustained rate is set by points per sample.
// Synchronous reset clears the pipeline, queue and column state and loads
// register defaults. A stalled rsp backs up the 8-entry queue; req.ready drops
// once queued entries plus samples in flight reach its depth, until entries drain.
// ----------------------------------------------------------------------------
module minmax_waveform_decimator_unit #(
   parameter int INDEX_BITS  = 40,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   mwd_req_if.sink                           req,
   mwd_rsp_if.source                         rsp,
   input  logic                              csr_wr_en,
   input  logic [mwd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mwd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mwd_pkg::cfg_type               cfg_ff, cfg_in;
   logic                           push;
   mwd_pkg::evt_type               push_evt;
   logic                           pop;
   mwd_pkg::evt_type               head;
   logic [mwd_pkg::QCNT_W-1:0]     q_count;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (mwd_pkg::csr_idx_type'(csr_index))
            mwd_pkg::CSR_X_SCALE:           cfg_in.x_scale = csr_wdata[31:0];
            mwd_pkg::CSR_Y_GAIN:            cfg_in.y_gain = csr_wdata[23:0];
            mwd_pkg::CSR_CENTER_ROW:        cfg_in.center_row = csr_wdata[14:0];
            mwd_pkg::CSR_VIEW_FIRST_PIXEL:  cfg_in.view_first_pixel = csr_wdata[47:0];
            mwd_pkg::CSR_VIEW_FIRST_SAMPLE: cfg_in.view_first_sample = csr_wdata[39:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_scale           <= 32'd65536;
         cfg_ff.y_gain            <= 24'd5243;
         cfg_ff.center_row        <= '0;
         cfg_ff.view_first_pixel  <= '0;
         cfg_ff.view_first_sample <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mwd_front #(
      .INDEX_BITS  (INDEX_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg_ff),
      .q_count  (q_count),
      .push     (push),
      .push_evt (push_evt)
   );

   mwd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_evt (push_evt),
      .pop      (pop),
      .head     (head),
      .count    (q_count)
   );

   mwd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_count  (q_count),
      .pop      (pop),
      .rsp      (rsp)
   );

endmodule

### sv/mwd_front.sv
// ----------------------------------------------------------------------------
// Min/max waveform decimator front end
// Accepts samples, maps them to column and row, tracks the column extremes
// and writes the points that each sample causes into the point queue.
// ----------------------------------------------------------------------------
`include "minmax_waveform_decimator_unit_macros.svh"

module mwd_front #(
   parameter int INDEX_BITS  = 40,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   mwd_req_if.sink                      req,
   input  mwd_pkg::cfg_type             cfg,
   input  logic [mwd_pkg::QCNT_W-1:0]   q_count,
   output logic                         push,
   output mwd_pkg::evt_type             push_evt
);

   localparam int PROD_W = SAMPLE_BITS + 25;
   localparam int IDXX_W = INDEX_BITS + 32;
   localparam int VFSX_W = INDEX_BITS + 40;
   localparam int SMPX_W = SAMPLE_BITS + mwd_pkg::SAMPLE_W;
   localparam int OCC_W  = mwd_pkg::QCNT_W + 1;
   localparam logic signed [PROD_W-1:0] Y_HALF  = PROD_W'(1) <<< 19;
   localparam logic signed [PROD_W:0]   ROW_MAX = (PROD_W+1)'(32767);
   localparam logic signed [PROD_W:0]   ROW_MIN = -(PROD_W+1)'(32768);

   logic                          accept;
   logic [OCC_W-1:0]              occupancy;
   logic [INDEX_BITS-1:0]         index_ff, index_in, idx_cur;
   logic [IDXX_W-1:0]             idx_ext;
   logic [VFSX_W-1:0]             vfs_ext;
   logic [SMPX_W-1:0]             smp_ext;
   logic signed [SAMPLE_BITS-1:0] smp;
   logic signed [24:0]            gain_s;
   logic [47:0]                   lo_prod;

   logic                          a_valid_ff, a_valid_in;
   logic [15:0]                   a_hi_ff, a_hi_in;
   logic [31:0]                   a_lo_ff, a_lo_in;
   logic signed [PROD_W-1:0]      a_prod_ff, a_prod_in;
   logic                          a_start_ff, a_start_in;
   logic                          a_eov_ff, a_eov_in;

   logic [31:0]                   lo_rnd;
   logic signed [PROD_W-1:0]      rnd, delta;
   logic signed [PROD_W:0]        row_full;

   logic                          b_valid_ff, b_valid_in;
   logic signed [15:0]            b_x_ff, b_x_in;
   logic signed [15:0]            b_y_ff, b_y_in;
   logic                          b_start_ff, b_start_in;
   logic                          b_eov_ff, b_eov_in;

   logic signed [15:0]            col_ff, col_in;
   logic signed [15:0]            entry_ff, entry_in;
   logic signed [15:0]            exit_ff, exit_in;
   logic signed [15:0]            max_ff, max_in;
   logic signed [15:0]            min_ff, min_in;
   logic                          pend_ff, pend_in;

   logic signed [15:0]            e_entry, e_exit, e_max, e_min;
   logic signed [15:0]            n_entry, n_exit, n_max, n_min;
   logic                          n_pend;
   logic                          same_col;
   mwd_pkg::point_type            cand [mwd_pkg::MAX_PTS];
   logic [mwd_pkg::MAX_PTS-1:0]   keep;
   logic [mwd_pkg::NPTS_W-1:0]    cnt;

   // credit: queue slots cover every item already in flight
   assign occupancy = {1'b0, q_count} + {{mwd_pkg::QCNT_W{1'b0}}, a_valid_ff}
                    + {{mwd_pkg::QCNT_W{1'b0}}, b_valid_ff};
   assign req.ready = occupancy < OCC_W'(mwd_pkg::QDEPTH);
   assign accept    = req.valid && req.ready;

   assign vfs_ext = {{INDEX_BITS{1'b0}}, cfg.view_first_sample};
   assign idx_cur = req.start_of_view ? vfs_ext[INDEX_BITS-1:0] : index_ff;
   assign idx_ext = {32'b0, idx_cur};
   assign smp_ext = {{SAMPLE_BITS{1'b0}}, req.sample_value};
   assign smp     = signed'(smp_ext[SAMPLE_BITS-1:0]);
   assign gain_s  = signed'({1'b0, cfg.y_gain});
   assign lo_prod = idx_ext[31:0] * cfg.x_scale[15:0];

   always_comb begin
      index_in   = accept ? idx_cur + 1'b1 : index_ff;
      a_valid_in = accept;
      a_hi_in    = 16'(idx_cur[15:0] * cfg.x_scale[31:16]);
      a_lo_in    = lo_prod[31:0];
      a_prod_in  = smp * gain_s;
      a_start_in = req.start_of_view;
      a_eov_in   = req.end_of_view;
   end

   // column and row, round half up
   assign lo_rnd   = a_lo_ff + 32'h0000_8000;
   assign rnd      = a_prod_ff + Y_HALF;
   assign delta    = rnd >>> 20;
   assign row_full = signed'({{(PROD_W-14){1'b0}}, cfg.center_row}) - {delta[PROD_W-1], delta};

   always_comb begin
      b_valid_in = a_valid_ff;
      b_x_in     = a_hi_ff + lo_rnd[31:16] - cfg.view_first_pixel[15:0];
      if (row_full > ROW_MAX) begin
         b_y_in = 16'sh7FFF;
      end else if (row_full < ROW_MIN) begin
         b_y_in = -16'sh8000;
      end else begin
         b_y_in = row_full[15:0];
      end
      b_start_in = a_start_ff;
      b_eov_in   = a_eov_ff;
   end

   // classify against the tracked column
   always_comb begin
      e_entry  = b_start_ff ? '0 : entry_ff;
      e_exit   = b_start_ff ? '0 : exit_ff;
      e_max    = b_start_ff ? '0 : max_ff;
      e_min    = b_start_ff ? '0 : min_ff;
      same_col = !b_start_ff && (b_x_ff == col_ff);
      for (int i = 0; i < mwd_pkg::MAX_PTS; i++) begin
         cand[i] = '0;
      end
      keep = '0;
      if (same_col) begin
         n_max   = (b_y_ff > e_max) ? b_y_ff : e_max;
         n_min   = (b_y_ff > e_max) ? e_min : ((b_y_ff < e_min) ? b_y_ff : e_min);
         n_exit  = b_y_ff;
         n_entry = e_entry;
         n_pend  = !b_eov_ff;
         cand[0] = '{x: b_x_ff, y: n_max};
         cand[1] = '{x: b_x_ff, y: n_min};
         keep[0] = b_eov_ff && (n_max > n_entry);
         keep[1] = b_eov_ff && (n_min < n_entry);
      end else begin
         n_max   = b_y_ff;
         n_min   = b_y_ff;
         n_exit  = b_y_ff;
         n_entry = b_y_ff;
         n_pend  = 1'b0;
         cand[0] = '{x: col_ff, y: e_max};
         cand[1] = '{x: col_ff, y: e_min};
         cand[2] = '{x: col_ff, y: e_exit};
         cand[3] = '{x: b_x_ff, y: b_y_ff};
         keep[0] = e_max > e_entry;
         keep[1] = e_min < e_entry;
         keep[2] = (e_exit != e_min) && (e_exit != e_max);
         keep[3] = 1'b1;
      end
      push_evt = '0;
      cnt      = '0;
      for (int i = 0; i < mwd_pkg::MAX_PTS; i++) begin
         if (keep[i]) begin
            push_evt.pts[cnt[1:0]] = cand[i];
            cnt = cnt + 1'b1;
         end
      end
      push_evt.n = cnt;
      push       = b_valid_ff && (cnt != '0);

      col_in   = b_valid_ff ? b_x_ff : col_ff;
      entry_in = b_valid_ff ? n_entry : entry_ff;
      exit_in  = b_valid_ff ? n_exit : exit_ff;
      max_in   = b_valid_ff ? n_max : max_ff;
      min_in   = b_valid_ff ? n_min : min_ff;
      pend_in  = b_valid_ff ? n_pend : pend_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff   <= '0;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         col_ff     <= '1;
         entry_ff   <= '0;
         exit_ff    <= '0;
         max_ff     <= '0;
         min_ff     <= '0;
         pend_ff    <= 1'b0;
      end else begin
         index_ff   <= index_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         col_ff     <= col_in;
         entry_ff   <= entry_in;
         exit_ff    <= exit_in;
         max_ff     <= max_in;
         min_ff     <= min_in;
         pend_ff    <= pend_in;
      end
      a_hi_ff    <= a_hi_in;
      a_lo_ff    <= a_lo_in;
      a_prod_ff  <= a_prod_in;
      a_start_ff <= a_start_in;
      a_eov_ff   <= a_eov_in;
      b_x_ff     <= b_x_in;
      b_y_ff     <= b_y_in;
      b_start_ff <= b_start_in;
      b_eov_ff   <= b_eov_in;
   end

   `MWD_ASSERT_IMP(a_front_credit, clock, reset, 1'b1, occupancy <= OCC_W'(mwd_pkg::QDEPTH))

endmodule

### sv/mwd_queue.sv
// ----------------------------------------------------------------------------
// Min/max waveform decimator point queue
// Short FIFO of point groups between the front end and the output stage.
// ----------------------------------------------------------------------------
`include "minmax_waveform_decimator_unit_macros.svh"

module mwd_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mwd_pkg::evt_type            push_evt,
   input  logic                        pop,
   output mwd_pkg::evt_type            head,
   output logic [mwd_pkg::QCNT_W-1:0]  count
);

   mwd_pkg::evt_type               entries_ff [mwd_pkg::QDEPTH];
   logic [mwd_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [mwd_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [mwd_pkg::QCNT_W-1:0]     count_ff, count_in;

   assign head  = entries_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + {{(mwd_pkg::QCNT_W-1){1'b0}}, push}
                - {{(mwd_pkg::QCNT_W-1){1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_evt;
      end
   end

   `MWD_ASSERT_IMP(a_q_no_overflow, clock, reset, push, (count_ff < mwd_pkg::QCNT_W'(mwd_pkg::QDEPTH)) || pop)
   `MWD_ASSERT_IMP(a_q_no_underflow, clock, reset, pop, count_ff != '0)
   `MWD_ASSERT_NXT(a_q_grow, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1)

endmodule

### sv/mwd_back.sv
// ----------------------------------------------------------------------------
// Min/max waveform decimator output stage
// Walks the points of the head queue entry, one per transaction, through
// a registered output.
// ----------------------------------------------------------------------------
`include "minmax_waveform_decimator_unit_macros.svh"

module mwd_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mwd_pkg::evt_type            head,
   input  logic [mwd_pkg::QCNT_W-1:0]  q_count,
   output logic                        pop,
   mwd_rsp_if.source                   rsp
);

   logic                 can_load;
   logic                 have;
   logic                 last_pt;
   logic [1:0]           k_ff, k_in;
   logic                 out_valid_ff, out_valid_in;
   mwd_pkg::point_type   out_pt_ff, out_pt_in;
   logic                 out_last_ff, out_last_in;

   assign can_load = !out_valid_ff || rsp.ready;
   assign have     = q_count != '0;
   assign last_pt  = {1'b0, k_ff} == (head.n - 1'b1);
   assign pop      = can_load && have && last_pt;

   always_comb begin
      k_in         = k_ff;
      out_valid_in = out_valid_ff;
      out_pt_in    = out_pt_ff;
      out_last_in  = out_last_ff;
      if (can_load) begin
         out_valid_in = have;
         if (have) begin
            out_pt_in   = head.pts[k_ff];
            out_last_in = last_pt;
            k_in        = last_pt ? 2'd0 : k_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
      end
      out_pt_ff   <= out_pt_in;
      out_last_ff <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.x_pos       = out_pt_ff.x;
   assign rsp.y_pos       = out_pt_ff.y;
   assign rsp.last_of_run = out_last_ff;

   `MWD_ASSERT_IMP(a_back_nonempty_entry, clock, reset, have, head.n != '0)
   `MWD_ASSERT_IMP(a_back_index_in_range, clock, reset, have, {1'b0, k_ff} < head.n)

endmodule

### tb/sv/tb_minmax_waveform_decimator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Min/max waveform decimator testbench
// Drives sample transactions into the decimator and checks every point it
// sends against an in-bench column tracker. A short table covers reset values,
// sample extremes, row saturation, column and index wrap, end-of-view flush
// and start plus end on one sample. Random views then run under several
// register settings, the first four with idle cycles on both channels, and
// one long output stall that backs up the point queue.
// ----------------------------------------------------------------------------
module tb_minmax_waveform_decimator_unit;

   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_ITEMS     = 50;
   localparam int NUM_DIR_ROWS    = 22;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic        last;
   } point_exp_type;

   typedef struct packed {
      logic [1:0]  phase;
      logic [15:0] sample_val;
      logic        sov;
      logic        eov;
      logic        typed;
      logic [15:0] tx;
      logic [15:0] ty;
   } stim_row_type;

   logic clock;
   logic reset;
   logic                           csr_wr_en;
   logic [mwd_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mwd_pkg::CSR_DATA_W-1:0] csr_wdata;

   mwd_req_if req_ch ();
   mwd_rsp_if rsp_ch ();

   minmax_waveform_decimator_unit #(
      .INDEX_BITS  (40),
      .SAMPLE_BITS (16)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow registers and column state
   mwd_pkg::cfg_type shadow_cfg;
   logic [39:0]      view_index;
   logic [15:0]      view_column;
   int               col_entry_row;
   int               col_exit_row;
   int               col_max_row;
   int               col_min_row;
   bit               col_pending;

   point_exp_type column_points[$];
   point_exp_type expected_points[$];

   int mismatch_count = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_off_req   = 0;
   int hold_off_ack   = 0;
   int hold_off_left  = 0;
   int quiet_cycles   = 0;

   mwd_pkg::cfg_type dir_settings [3] = '{
      '{32'h0001_0000, 24'd5243, 15'd0, 48'd0, 40'd0},
      '{32'h0000_4000, 24'h10_0000, 15'd100, 48'hFFFF_FFFF_FFF0, 40'hFF_FFFF_FFFE},
      '{32'hFFFF_FFFF, 24'hFF_FFFF, 15'h7FFF, 48'd0, 40'd0}
   };

   stim_row_type dir_rows [NUM_DIR_ROWS] = '{
      '{2'd0, 16'h0000, 1'b0, 1'b0, 1'b1, 16'd0, 16'h0000},
      '{2'd0, 16'h7FFF, 1'b0, 1'b0, 1'b1, 16'd1, 16'hFF5C},
      '{2'd0, 16'h8000, 1'b0, 1'b0, 1'b1, 16'd2, 16'h00A4},
      '{2'd0, 16'h0001, 1'b0, 1'b1, 1'b1, 16'd3, 16'h0000},
      '{2'd1, 16'h0000, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h001E, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'hFFD8, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h0007, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h0064, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'hFF9C, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h0005, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h0003, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'hFFF6, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h0040, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'h0040, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd1, 16'hFFC0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'h7FFF, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'h8000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'h0001, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'hFFFF, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0},
      '{2'd2, 16'h8000, 1'b1, 1'b1, 1'b0, 16'd0, 16'd0}
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] pixel_column(logic [39:0] idx);
      logic [63:0] px;
      px = 64'(idx) * 64'(shadow_cfg.x_scale[31:16])
         + ((64'(idx) * 64'(shadow_cfg.x_scale[15:0]) + 64'h8000) >> 16);
      return px[15:0] - shadow_cfg.view_first_pixel[15:0];
   endfunction

   function automatic int sample_row(logic signed [15:0] s);
      longint gain;
      longint center;
      longint delta;
      longint row;
      gain   = longint'(shadow_cfg.y_gain);
      center = longint'(shadow_cfg.center_row);
      delta  = (longint'(s) * gain + 524288) >>> 20;
      row    = center - delta;
      if (row > 32767) row = 32767;
      if (row < -32768) row = -32768;
      return int'(row);
   endfunction

   function automatic void load_view();
      view_index    = shadow_cfg.view_first_sample;
      view_column   = pixel_column(view_index) - 16'd1;
      col_entry_row = 0;
      col_exit_row  = 0;
      col_max_row   = 0;
      col_min_row   = 0;
      col_pending   = 1'b0;
   endfunction

   function automatic void emit_point(logic [15:0] col, int row);
      point_exp_type pt;
      pt.x    = col;
      pt.y    = row[15:0];
      pt.last = 1'b0;
      column_points.push_back(pt);
   endfunction

   function automatic void decimate_sample(logic signed [15:0] s, bit sov, bit eov);
      logic [15:0] col;
      int          row;
      column_points.delete();
      if (sov) load_view();
      col        = pixel_column(view_index);
      view_index = view_index + 40'd1;
      row        = sample_row(s);
      if (col == view_column) begin
         if (row > col_max_row) col_max_row = row;
         else if (row < col_min_row) col_min_row = row;
         col_exit_row = row;
         col_pending  = 1'b1;
      end else begin
         if (col_max_row > col_entry_row) emit_point(view_column, col_max_row);
         if (col_min_row < col_entry_row) emit_point(view_column, col_min_row);
         if (col_exit_row != col_min_row && col_exit_row != col_max_row)
            emit_point(view_column, col_exit_row);
         emit_point(col, row);
         col_entry_row = row;
         col_exit_row  = row;
         col_max_row   = row;
         col_min_row   = row;
         col_pending   = 1'b0;
      end
      view_column = col;
      if (eov && col_pending) begin
         if (col_max_row > col_entry_row) emit_point(view_column, col_max_row);
         if (col_min_row < col_entry_row) emit_point(view_column, col_min_row);
         col_pending = 1'b0;
      end
   endfunction

   function automatic void check_point();
      point_exp_type exp_pt;
      if (expected_points.size() == 0) begin
         $display("%0t: unexpected point x_pos=%0d y_pos=%0d last_of_run=%0b", $time,
                  rsp_ch.x_pos, rsp_ch.y_pos, rsp_ch.last_of_run);
         mismatch_count++;
         return;
      end
      exp_pt = expected_points.pop_front();
      if (rsp_ch.x_pos !== exp_pt.x) begin
         $display("%0t: x_pos mismatch: expected %0d, actual %0d", $time,
                  $signed(exp_pt.x), rsp_ch.x_pos);
         mismatch_count++;
      end
      if (rsp_ch.y_pos !== exp_pt.y) begin
         $display("%0t: y_pos mismatch: expected %0d, actual %0d", $time,
                  $signed(exp_pt.y), rsp_ch.y_pos);
         mismatch_count++;
      end
      if (rsp_ch.last_of_run !== exp_pt.last) begin
         $display("%0t: last_of_run mismatch: expected %0b, actual %0b", $time,
                  exp_pt.last, rsp_ch.last_of_run);
         mismatch_count++;
      end
   endfunction

   // point receiver with random stalls and one long hold-off on request
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) check_point();
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off_ack != hold_off_req) begin
         hold_off_ack  <= hold_off_req;
         hold_off_left <= HOLD_OFF_CYCLES;
         rsp_ch.ready  <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ch.ready  <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
         $display("** minmax_waveform_decimator_unit: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(logic [15:0] s, bit sov, bit eov, bit typed,
                              logic [15:0] tx, logic [15:0] ty);
      point_exp_type pt;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.sample_value  <= s;
      req_ch.start_of_view <= sov;
      req_ch.end_of_view   <= eov;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      decimate_sample(s, sov, eov);
      if (typed) begin
         pt.x    = tx;
         pt.y    = ty;
         pt.last = 1'b1;
         expected_points.push_back(pt);
      end else begin
         foreach (column_points[k]) begin
            pt      = column_points[k];
            pt.last = (k == column_points.size() - 1);
            expected_points.push_back(pt);
         end
      end
   endtask

   // drop valid and wait until every point is back and the pipeline is empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(mwd_pkg::csr_idx_type idx,
                            logic [mwd_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_setting(mwd_pkg::cfg_type c);
      csr_write(mwd_pkg::CSR_X_SCALE, 48'(c.x_scale));
      csr_write(mwd_pkg::CSR_Y_GAIN, 48'(c.y_gain));
      csr_write(mwd_pkg::CSR_CENTER_ROW, 48'(c.center_row));
      csr_write(mwd_pkg::CSR_VIEW_FIRST_PIXEL, c.view_first_pixel);
      csr_write(mwd_pkg::CSR_VIEW_FIRST_SAMPLE, 48'(c.view_first_sample));
      csr_wr_en  <= 1'b0;
      shadow_cfg = c;
   endtask

   function automatic mwd_pkg::cfg_type random_setting(int p);
      mwd_pkg::cfg_type c;
      c.x_scale           = $urandom;
      c.y_gain            = 24'($urandom);
      c.center_row        = 15'($urandom);
      c.view_first_pixel  = {16'($urandom), 32'($urandom)};
      c.view_first_sample = {8'($urandom), 32'($urandom)};
      unique case (p)
         0: c = '{32'h0001_0000, 24'd5243, 15'd0, 48'd0, 40'd0};
         1: c.x_scale = 32'h0000_2800;
         2: begin
            c.x_scale           = 32'd1;
            c.view_first_pixel  = 48'hFFFF_FFFF_FFFF;
            c.view_first_sample = 40'd0;
         end
         3: c = '{32'hFFFF_FFFF, 24'hFF_FFFF, 15'h7FFF, 48'd0, 40'hFF_FFFF_FFFF};
         4: begin
            c.x_scale    = $urandom_range(32'h0003_0000, 32'h0000_0800);
            c.y_gain     = 24'd0;
            c.center_row = 15'd0;
         end
         default: c.view_first_sample = 40'hFF_FFFF_FFFF - 40'($urandom_range(60));
      endcase
      return c;
   endfunction

   function automatic logic [15:0] pick_sample(logic [15:0] prev);
      unique case ($urandom_range(9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2, 3, 4: return 16'($urandom);
         default: return prev + 16'($urandom_range(400)) - 16'd200;
      endcase
   endfunction

   initial begin
      logic [1:0]  cur_phase;
      logic [15:0] s;
      int          items;
      int          len;
      bit          first;
      bit          pressure_done;

      reset                <= 1'b1;
      csr_wr_en            <= 1'b0;
      csr_index            <= mwd_pkg::CSR_X_SCALE;
      csr_wdata            <= '0;
      req_ch.valid         <= 1'b0;
      req_ch.sample_value  <= '0;
      req_ch.start_of_view <= 1'b0;
      req_ch.end_of_view   <= 1'b0;
      shadow_cfg           = dir_settings[0];
      load_view();
      pressure_done        = 1'b0;
      s                    = '0;

      repeat (3) @(posedge clock);
      reset         <= 1'b0;
      send_idle_pct <= 14;
      recv_idle_pct <= 47;

      cur_phase = 2'd0;
      foreach (dir_rows[i]) begin
         if (dir_rows[i].phase != cur_phase) begin
            settle();
            cur_phase = dir_rows[i].phase;
            apply_setting(dir_settings[cur_phase]);
         end
         send_sample(dir_rows[i].sample_val, dir_rows[i].sov, dir_rows[i].eov,
                     dir_rows[i].typed, dir_rows[i].tx, dir_rows[i].ty);
      end

      for (int p = 0; p < 6; p++) begin
         settle();
         apply_setting(random_setting(p));
         send_idle_pct <= (p < 2) ? 14 : (p < 4) ? 47 : 0;
         recv_idle_pct <= (p < 2) ? 47 : (p < 4) ? 14 : 0;
         items = 0;
         first = 1'b1;
         while (items < PHASE_ITEMS) begin
            if (!first && $urandom_range(9) == 0) begin
               // broken sequence: random flags
               s = pick_sample(s);
               send_sample(s, 1'($urandom_range(1)), 1'($urandom_range(1)), 1'b0, '0, '0);
               items++;
            end else begin
               len = ($urandom_range(7) == 0) ? $urandom_range(40, 20) : $urandom_range(12, 1);
               for (int k = 0; k < len; k++) begin
                  s = pick_sample(s);
                  send_sample(s, k == 0, k == len - 1, 1'b0, '0, '0);
               end
               items += len;
            end
            first = 1'b0;
            if (p == 4 && !pressure_done && items > 15) begin
               hold_off_req  <= hold_off_req + 1;
               pressure_done = 1'b1;
            end
         end
      end

      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("** minmax_waveform_decimator_unit: PASSED **");
      end else begin
         $display("** minmax_waveform_decimator_unit: FAILED **");
      end
      $finish;
   end

endmodule

### minmax_waveform_decimator_unit.f
+incdir+sv
sv/mwd_pkg.sv
sv/mwd_if.sv
sv/mwd_front.sv
sv/mwd_queue.sv
sv/mwd_back.sv
sv/minmax_waveform_decimator_unit.sv
tb/sv/tb_minmax_waveform_decimator_unit.sv
